>>> hdl/first_fit_allocator_top_macros.svh
// Assertion helpers for the allocator; clocked on clk_i, disabled in reset.
`ifndef FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define FFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned POOL_BYTES    = 1048576;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned FREE_SEGMENTS = 16;
  localparam int unsigned USED_SLOTS    = 32;

  localparam int unsigned AddrW = 20;
  localparam int unsigned SizeW = 21;
  localparam int unsigned StatW = 3;
  localparam int unsigned PtrW  = 21;
  localparam int unsigned SumW  = 22;
  localparam int unsigned FIdxW = $clog2(FREE_SEGMENTS);
  localparam int unsigned CntW  = $clog2(FREE_SEGMENTS + 1);
  localparam int unsigned UIdxW = $clog2(USED_SLOTS);

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_ALLOC_FULL = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_FREE_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef struct packed {
    logic [PtrW-1:0]  start;
    logic [SizeW-1:0] len;
  } seg_t;

  typedef struct packed {
    cell_op_e op;
    seg_t     load;
  } cell_cmd_t;

  localparam int unsigned SegW = $bits(seg_t);
  localparam logic [SizeW-1:0] InitLen = SizeW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [SumW-1:0]  Hdr     = SumW'(HEADER_BYTES);

endpackage

>>> hdl/ffa_ram.sv
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ffa_cell.sv
module ffa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              first_i,
  input  ffa_pkg::cell_cmd_t cmd_i,
  input  ffa_pkg::seg_t     left_i,
  input  ffa_pkg::seg_t     right_i,
  output ffa_pkg::seg_t     seg_o
);
  import ffa_pkg::*;

  seg_t seg_q, seg_d;

  always_comb begin
    unique case (cmd_i.op)
      CELL_LOAD:       seg_d = cmd_i.load;
      CELL_FROM_LEFT:  seg_d = left_i;
      CELL_FROM_RIGHT: seg_d = right_i;
      default:         seg_d = seg_q;
    endcase
  end

  // The first cell holds the whole pool out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.start <= '0;
      seg_q.len   <= first_i ? InitLen : '0;
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

>>> hdl/first_fit_allocator_top.sv
// Allocation scans the free segments for the first fit, then the slots for a free one;
// it fails on no fit or a full slot table. A free of address 0 returns OK with no lookup;
// others look up each allocation slot (registered RAM read), then walk the free segments and
// merge or insert, failing on an unknown address or a full segment table. One request at a
// time; the next is taken in the strobe cycle at the earliest.
// Reset: free segment cell 0 holds the pool, all slots free; no clearing pass.
`include "first_fit_allocator_top_macros.svh"
module first_fit_allocator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      command_i,
  input  logic [ffa_pkg::SizeW-1:0] request_size_i,
  input  logic [ffa_pkg::AddrW-1:0] block_address_i,
  output logic                      done_o,
  output logic [ffa_pkg::AddrW-1:0] result_address_o,
  output logic [ffa_pkg::SizeW-1:0] granted_size_o,
  output logic [ffa_pkg::StatW-1:0] status_o
);
  import ffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_AFIT, S_ASLOT, S_AAPPLY, S_FRD, S_FCMP, S_FPOS, S_FAPPLY
  } state_e;

  typedef enum logic [2:0] {
    AP_NONE, AP_LOAD, AP_REMOVE, AP_INSERT, AP_LOAD_REMOVE
  } apply_e;

  state_e state_q, state_d;
  logic [SizeW-1:0] size_q, size_d, len_q, len_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CntW-1:0]  fi_q, fi_d, count_q, count_d;
  logic [UIdxW-1:0] slot_q, slot_d;
  logic [USED_SLOTS-1:0] used_q, used_d;
  logic done_q, done_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic [SizeW-1:0] res_size_q, res_size_d;
  status_e status_q, status_d;

  seg_t      segs [FREE_SEGMENTS];
  cell_cmd_t cmds [FREE_SEGMENTS];
  apply_e    ap;
  logic [FIdxW-1:0] ld_idx;
  logic [CntW-1:0]  sh_idx;
  seg_t             ld_seg;

  logic             ram_we;
  logic [UIdxW-1:0] ram_raddr;
  seg_t             ram_wdata, ram_rdata;

  seg_t cur, prv;
  logic [SumW-1:0] size22, addr22, pay22, nstart22, nlen22;
  logic [SumW-1:0] next_len, prev_len, both_len;
  logic [SizeW-1:0] granted;
  logic split, mnext, mprev, pos_lt_n;

  assign cur = segs[fi_q[FIdxW-1:0]];
  assign prv = segs[fi_q[FIdxW-1:0] - 1'b1];

  assign size22   = {1'b0, size_q};
  assign addr22   = {2'b0, addr_q};
  assign pos_lt_n = fi_q < count_q;
  assign split    = {1'b0, cur.len} >= size22 + Hdr;
  assign pay22    = {1'b0, cur.start} + Hdr;
  assign nstart22 = pay22 + size22;
  assign nlen22   = {1'b0, cur.len} - size22 - Hdr;
  assign granted  = split ? size_q : cur.len;
  assign mnext    = pos_lt_n && (addr22 + {1'b0, len_q} == {1'b0, cur.start});
  assign mprev    = (fi_q != '0) &&
                    ({1'b0, prv.start} + {1'b0, prv.len} + Hdr + Hdr == addr22);
  assign next_len = {1'b0, cur.len} + Hdr + {1'b0, len_q};
  assign prev_len = {1'b0, prv.len} + Hdr + {1'b0, len_q};
  assign both_len = prev_len + Hdr + {1'b0, cur.len};

  ffa_ram #(.Width(SegW), .Depth(USED_SLOTS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    addr_d     = addr_q;
    len_d      = len_q;
    fi_d       = fi_q;
    slot_d     = slot_q;
    count_d    = count_q;
    used_d     = used_q;
    done_d     = 1'b0;
    res_addr_d = res_addr_q;
    res_size_d = res_size_q;
    status_d   = status_q;
    ap         = AP_NONE;
    ld_idx     = fi_q[FIdxW-1:0];
    sh_idx     = fi_q;
    ld_seg     = cur;
    ram_we     = 1'b0;
    ram_raddr  = slot_q;
    ram_wdata  = '{start: pay22[PtrW-1:0], len: granted};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          size_d  = request_size_i;
          addr_d  = block_address_i;
          fi_d    = '0;
          slot_d  = '0;
          state_d = command_i ? S_FRD : S_AFIT;
        end
      end
      S_AFIT: begin
        if (!pos_lt_n) begin
          done_d = 1'b1; res_addr_d = '0; res_size_d = '0; status_d = ST_NO_FIT;
          state_d = S_IDLE;
        end else if (cur.len >= size_q) begin
          state_d = S_ASLOT;
        end else begin
          fi_d = fi_q + 1'b1;
        end
      end
      S_ASLOT: begin
        if (!used_q[slot_q]) begin
          state_d = S_AAPPLY;
        end else if (slot_q == UIdxW'(USED_SLOTS - 1)) begin
          done_d = 1'b1; res_addr_d = '0; res_size_d = '0; status_d = ST_ALLOC_FULL;
          state_d = S_IDLE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_AAPPLY: begin
        ram_we         = 1'b1;
        used_d[slot_q] = 1'b1;
        if (split) begin
          ap     = AP_LOAD;
          ld_seg = '{start: nstart22[PtrW-1:0], len: nlen22[SizeW-1:0]};
        end else begin
          ap      = AP_REMOVE;
          count_d = count_q - 1'b1;
        end
        done_d     = 1'b1;
        res_addr_d = pay22[AddrW-1:0];
        res_size_d = granted;
        status_d   = ST_OK;
        state_d    = S_IDLE;
      end
      S_FRD: begin
        if (addr_q == '0) begin
          done_d = 1'b1; res_addr_d = '0; res_size_d = '0; status_d = ST_OK;
          state_d = S_IDLE;
        end else begin
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (used_q[slot_q] && ram_rdata.start == {1'b0, addr_q}) begin
          len_d   = ram_rdata.len;
          fi_d    = '0;
          state_d = S_FPOS;
        end else if (slot_q == UIdxW'(USED_SLOTS - 1)) begin
          done_d = 1'b1; res_addr_d = '0; res_size_d = '0; status_d = ST_UNKNOWN;
          state_d = S_IDLE;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_FPOS: begin
        // advance while the segment header lies below the freed header
        if (pos_lt_n && ({1'b0, cur.start} + Hdr < addr22)) begin
          fi_d = fi_q + 1'b1;
        end else begin
          state_d = S_FAPPLY;
        end
      end
      S_FAPPLY: begin
        done_d = 1'b1; res_addr_d = '0; res_size_d = '0; status_d = ST_OK;
        state_d = S_IDLE;
        if (!mprev && !mnext && count_q >= CntW'(FREE_SEGMENTS)) begin
          status_d = ST_FREE_FULL;
        end else begin
          used_d[slot_q] = 1'b0;
          priority if (mprev && mnext) begin
            ap      = AP_LOAD_REMOVE;
            ld_idx  = fi_q[FIdxW-1:0] - 1'b1;
            ld_seg  = '{start: prv.start, len: both_len[SizeW-1:0]};
            count_d = count_q - 1'b1;
          end else if (mprev) begin
            ap     = AP_LOAD;
            ld_idx = fi_q[FIdxW-1:0] - 1'b1;
            ld_seg = '{start: prv.start, len: prev_len[SizeW-1:0]};
          end else if (mnext) begin
            ap     = AP_LOAD;
            ld_seg = '{start: PtrW'(addr22 - Hdr), len: next_len[SizeW-1:0]};
          end else begin
            ap      = AP_INSERT;
            ld_seg  = '{start: PtrW'(addr22 - Hdr), len: len_q};
            count_d = count_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Per-cell commands: load one cell, shift a run toward or away from the head.
  always_comb begin
    for (int j = 0; j < FREE_SEGMENTS; j++) begin
      cmds[j].load = ld_seg;
      priority if ((ap == AP_LOAD || ap == AP_LOAD_REMOVE || ap == AP_INSERT) &&
                   FIdxW'(j) == ld_idx) begin
        cmds[j].op = CELL_LOAD;
      end else if ((ap == AP_REMOVE || ap == AP_LOAD_REMOVE) &&
                   CntW'(j) >= sh_idx && j < FREE_SEGMENTS - 1) begin
        cmds[j].op = CELL_FROM_RIGHT;
      end else if (ap == AP_INSERT && CntW'(j) > sh_idx) begin
        cmds[j].op = CELL_FROM_LEFT;
      end else begin
        cmds[j].op = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < FREE_SEGMENTS; g++) begin : g_cell
    seg_t left_s, right_s;
    if (g == 0) begin : g_head
      assign left_s = '0;
    end else begin : g_mid
      assign left_s = segs[g-1];
    end
    if (g == FREE_SEGMENTS - 1) begin : g_tail
      assign right_s = segs[g];
    end else begin : g_body
      assign right_s = segs[g+1];
    end
    ffa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .first_i (g == 0),
      .cmd_i   (cmds[g]),
      .left_i  (left_s),
      .right_i (right_s),
      .seg_o   (segs[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CntW'(1);
      used_q  <= '0;
      done_q  <= 1'b0;
      fi_q    <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      used_q  <= used_d;
      done_q  <= done_d;
      fi_q    <= fi_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    res_addr_q <= res_addr_d;
    res_size_q <= res_size_d;
    status_q   <= status_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign result_address_o = res_addr_q;
  assign granted_size_o   = res_size_q;
  assign status_o         = status_q;

  `FFA_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CntW'(FREE_SEGMENTS), "free count overflow")
  `FFA_ASSERT_IMPL(a_fail_zero, done_o && status_o != ST_OK,
                   result_address_o == '0 && granted_size_o == '0, "failed result not zero")
  `FFA_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "request accepted but not busy")

endmodule

>>> sim/tb_first_fit_allocator_top.sv
`timescale 1ns / 100ps

module tb_first_fit_allocator_top;
  import ffa_pkg::*;

  localparam int unsigned NumRandom  = 1350;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned QuietTail  = 200;

  typedef struct {
    bit                command;
    logic [SizeW-1:0]  size;
    logic [AddrW-1:0]  addr;
    bit                drain;
    bit                quiet;
  } request_t;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    status_e          status;
  } grant_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              command_i;
  logic [SizeW-1:0]  request_size_i;
  logic [AddrW-1:0]  block_address_i;
  logic              done_o;
  logic [AddrW-1:0]  result_address_o;
  logic [SizeW-1:0]  granted_size_o;
  logic [StatW-1:0]  status_o;

  first_fit_allocator_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .done_o           (done_o),
    .result_address_o (result_address_o),
    .granted_size_o   (granted_size_o),
    .status_o         (status_o)
  );

  // shadow allocator state
  int unsigned seg_start [FREE_SEGMENTS];
  int unsigned seg_len   [FREE_SEGMENTS];
  int unsigned seg_cnt;
  int unsigned slot_addr [USED_SLOTS];
  int unsigned slot_len  [USED_SLOTS];
  bit          slot_live [USED_SLOTS];

  request_t    pending_requests[$];
  grant_t      expected_grants[$];
  int unsigned live_blocks[$];
  int unsigned error_cnt = 0;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned gap_cnt;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_cnt++;
  endtask

  function automatic void drop_segment(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k + 1];
      seg_len[k]   = seg_len[k + 1];
    end
    if (seg_cnt > 0) seg_cnt--;
  endfunction

  function automatic grant_t allocate(input int unsigned sz);
    grant_t      g;
    int unsigned i, slot, base, len, got;
    bit          found;
    g = '{addr: '0, size: '0, status: ST_OK};
    found = 0;
    for (i = 0; i < seg_cnt; i++) begin
      if (seg_len[i] >= sz) begin
        found = 1;
        break;
      end
    end
    if (!found) begin
      g.status = ST_NO_FIT;
      return g;
    end
    for (slot = 0; slot < USED_SLOTS; slot++)
      if (!slot_live[slot]) break;
    if (slot >= USED_SLOTS) begin
      g.status = ST_ALLOC_FULL;
      return g;
    end
    base = seg_start[i];
    len  = seg_len[i];
    if (len >= sz + HEADER_BYTES) begin
      seg_start[i] = base + HEADER_BYTES + sz;
      seg_len[i]   = len - sz - HEADER_BYTES;
      got = sz;
    end else begin
      drop_segment(i);
      got = len;
    end
    slot_live[slot] = 1;
    slot_addr[slot] = base + HEADER_BYTES;
    slot_len[slot]  = got;
    g.addr = AddrW'(base + HEADER_BYTES);
    g.size = SizeW'(got);
    return g;
  endfunction

  function automatic grant_t release_block(input int unsigned ad);
    grant_t      g;
    int unsigned slot, hdr, len, pos, n;
    bit          join_prev, join_next;
    g = '{addr: '0, size: '0, status: ST_OK};
    n = seg_cnt;
    if (ad == 0) return g;
    for (slot = 0; slot < USED_SLOTS; slot++)
      if (slot_live[slot] && slot_addr[slot] == ad) break;
    if (slot >= USED_SLOTS) begin
      g.status = ST_UNKNOWN;
      return g;
    end
    hdr = ad - HEADER_BYTES;
    len = slot_len[slot];
    for (pos = 0; pos < n && seg_start[pos] < hdr; pos++) ;
    join_next = pos < n && hdr + HEADER_BYTES + len == seg_start[pos];
    join_prev = pos > 0 && seg_start[pos - 1] + HEADER_BYTES + seg_len[pos - 1] == hdr;
    if (!join_prev && !join_next && n >= FREE_SEGMENTS) begin
      g.status = ST_FREE_FULL;
      return g;
    end
    slot_live[slot] = 0;
    if (join_prev && join_next) begin
      seg_len[pos - 1] += 2 * HEADER_BYTES + len + seg_len[pos];
      drop_segment(pos);
    end else if (join_prev) begin
      seg_len[pos - 1] += HEADER_BYTES + len;
    end else if (join_next) begin
      seg_len[pos]  += HEADER_BYTES + len;
      seg_start[pos] = hdr;
    end else begin
      for (int unsigned k = n; k > pos; k--) begin
        seg_start[k] = seg_start[k - 1];
        seg_len[k]   = seg_len[k - 1];
      end
      seg_start[pos] = hdr;
      seg_len[pos]   = len;
      seg_cnt = n + 1;
    end
    return g;
  endfunction

  // queue a request and its expected grant; track live blocks for later frees
  task automatic push_request(input bit cmd, input int unsigned sz, input int unsigned ad,
                              input bit drain, input bit quiet);
    request_t r;
    grant_t   g;
    r = '{command: cmd, size: SizeW'(sz), addr: AddrW'(ad), drain: drain, quiet: quiet};
    if (!cmd) begin
      g = allocate(int'(r.size));
      if (g.status == ST_OK) live_blocks.push_back(g.addr);
    end else begin
      g = release_block(int'(r.addr));
      if (g.status == ST_OK && r.addr != 0) begin
        foreach (live_blocks[j]) begin
          if (live_blocks[j] == r.addr) begin
            live_blocks.delete(j);
            break;
          end
        end
      end
    end
    pending_requests.push_back(r);
    expected_grants.push_back(g);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t    r;
    bit          took;
    int unsigned acc_now;
    if (!rst_ni) begin
      start_i         <= 1'b0;
      command_i       <= 1'b0;
      request_size_i  <= '0;
      block_address_i <= '0;
      gap_cnt         <= 0;
      accepted_cnt    <= 0;
    end else begin
      took = start_i && !busy_o;
      acc_now = accepted_cnt + took;
      if (took) begin
        r = pending_requests.pop_front();
        accepted_cnt <= acc_now;
      end
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start_i <= 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain && checked_cnt < acc_now)) begin
        r = pending_requests[0];
        start_i         <= 1'b1;
        command_i       <= r.command;
        request_size_i  <= r.size;
        block_address_i <= r.addr;
        if (took && !r.quiet && $urandom_range(0, 4) == 0)
          gap_cnt <= $urandom_range(1, 16);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      checked_cnt <= 0;
    end else if (done_o) begin
      if (expected_grants.size() == 0) begin
        report("unexpected result, status", status_o, 0);
      end else begin
        g = expected_grants.pop_front();
        if (result_address_o !== g.addr) report("result_address", result_address_o, g.addr);
        if (granted_size_o !== g.size)   report("granted_size", granted_size_o, g.size);
        if (status_o !== g.status)       report("status", status_o, g.status);
      end
      checked_cnt <= checked_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned blk[$];
    int unsigned pick, sz;
    bit          quiet;
    seg_cnt = 1;
    foreach (seg_start[k]) begin
      seg_start[k] = 0;
      seg_len[k]   = 0;
    end
    seg_len[0] = POOL_BYTES - HEADER_BYTES;
    foreach (slot_live[k]) begin
      slot_live[k] = 0;
      slot_addr[k] = 0;
      slot_len[k]  = 0;
    end
    rst_ni = 1'b0;

    // directed: edge sizes, null and stray frees
    push_request(0, 0, 0, 0, 0);
    push_request(0, POOL_BYTES, 0, 0, 0);
    push_request(0, (1 << SizeW) - 1, 0, 0, 0);
    push_request(1, 0, 0, 0, 0);
    push_request(1, 0, (1 << AddrW) - 1, 0, 0);
    push_request(1, 0, live_blocks[0], 0, 0);
    push_request(1, 0, HEADER_BYTES, 0, 0);
    // fill every slot, then one more to overflow the slot table
    for (int i = 0; i < USED_SLOTS + 1; i++) push_request(0, 32, 0, 0, 0);
    blk = live_blocks;
    // punch holes to fill the segment table, then free a lone block
    for (int i = 0; i < USED_SLOTS - 2; i += 2) push_request(1, 0, blk[i], 0, 0);
    push_request(1, 0, blk[USED_SLOTS - 2], 1, 0);
    push_request(1, 0, blk[1], 0, 0);
    push_request(1, 0, blk[3], 0, 0);
    push_request(1, 0, blk[USED_SLOTS - 1], 0, 0);
    while (live_blocks.size() > 0) push_request(1, 0, live_blocks[0], 0, 0);
    // whole pool in one grant (an exact fit), then a remainder too small to split
    push_request(0, POOL_BYTES - HEADER_BYTES, 0, 0, 0);
    push_request(0, 1, 0, 0, 0);
    push_request(1, 0, live_blocks[0], 1, 0);
    push_request(0, POOL_BYTES - 2 * HEADER_BYTES - 8, 0, 0, 0);
    push_request(0, 4, 0, 0, 0);
    while (live_blocks.size() > 0) push_request(1, 0, live_blocks[0], 0, 0);

    for (int i = 0; i < NumRandom; i++) begin
      quiet = i >= NumRandom - QuietTail;
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > 0 && pick < 45) begin
        push_request(1, $urandom, live_blocks[$urandom_range(0, live_blocks.size() - 1)],
                     i % 400 == 399, quiet);
      end else if (pick < 50) begin
        push_request(1, $urandom, $urandom, 0, quiet);
      end else if (pick < 53) begin
        push_request(1, $urandom, 0, 0, quiet);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      sz = $urandom_range(0, 64);
        else if (pick < 80) sz = $urandom_range(0, 4096);
        else if (pick < 95) sz = $urandom_range(0, 65536);
        else if (pick < 99) sz = $urandom_range(0, POOL_BYTES);
        else                sz = $urandom & ((1 << SizeW) - 1);
        push_request(0, sz, $urandom, 0, quiet);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || expected_grants.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/ffa_cell.sv
hdl/first_fit_allocator_top.sv
sim/tb_first_fit_allocator_top.sv
